// ===== rtl/core/pmq_pkg.sv =====
package pmq_pkg;

  localparam int CAPACITY  = 16;
  localparam int PRIO_BITS = 15;

  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int MAXMSG_W  = 5;
  localparam int SIZE_W    = 16;
  localparam int CMP_W     = (CNT_W > MAXMSG_W) ? CNT_W : MAXMSG_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [MAXMSG_W-1:0] MAX_MESSAGES_RST     = 5'd10;
  localparam logic [SIZE_W-1:0]   MAX_MESSAGE_SIZE_RST = 16'd8192;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_MESSAGES     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_MESSAGE_SIZE = 2'd1;

  localparam logic ACT_SEND    = 1'b0;
  localparam logic ACT_RECEIVE = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_LONG  = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_SMALL_BUF = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  typedef struct packed {
    logic        action;
    logic [15:0] msg_length;
    logic [14:0] priority_req;
    logic [31:0] payload_handle;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_length;
    logic [14:0] out_priority;
    logic [31:0] out_payload;
    logic [4:0]  queued_count;
  } out_rsp_t;

  typedef struct packed {
    logic [PRIO_BITS-1:0] prio;
    logic [15:0]          length;
    logic [31:0]          payload;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_RDHEAD = 5'b00010,
    S_SCAN   = 5'b00100,
    S_PLACE  = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W+1)'(CAPACITY)) s = s - (IDX_W+1)'(CAPACITY);
    return s[IDX_W-1:0];
  endfunction

endpackage

// ===== rtl/core/pmq_ram.sv =====
module pmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/priority_message_queue.sv =====
// A refused request or a send into an empty queue answers in the cycle after acceptance;
// a receive first passes S_RDHEAD; a send into a non-empty queue first passes S_SCAN (and S_PLACE).
// Throughput: one request at a time; the sorted insert walks back from the tail through the
// entry RAM, one read, one priority compare and one shifted write per cycle.
// Reset (synchronous, rst_n low) empties the queue and loads max_messages 10, size 8192;
// entry RAM contents are not cleared.
module priority_message_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  pmq_pkg::in_req_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output pmq_pkg::out_rsp_t                 out_data,
  input  logic                              cfg_we,
  input  logic [pmq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pmq_pkg::CFG_DAT_W-1:0]     cfg_wdata
);

  pmq_pkg::state_t                  state_r, state_nxt;
  logic [pmq_pkg::IDX_W-1:0]        head_r, head_nxt;
  logic [pmq_pkg::CNT_W-1:0]        count_r, count_nxt;
  logic [pmq_pkg::IDX_W-1:0]        j_r, j_nxt;
  pmq_pkg::entry_t                  ent_r, ent_nxt;
  pmq_pkg::out_rsp_t                out_r, out_nxt;
  logic [pmq_pkg::MAXMSG_W-1:0]     max_msgs_r;
  logic [pmq_pkg::SIZE_W-1:0]       max_size_r;

  logic                             ram_we;
  logic [pmq_pkg::IDX_W-1:0]        ram_waddr;
  pmq_pkg::entry_t                  ram_wdata;
  logic [pmq_pkg::IDX_W-1:0]        ram_raddr;
  pmq_pkg::entry_t                  ram_rdata;

  logic                             accept;
  logic                             full;
  pmq_pkg::entry_t                  new_ent;
  logic [pmq_pkg::CNT_W-1:0]        count_inc;
  logic [pmq_pkg::CNT_W-1:0]        count_dec;

  pmq_ram #(
    .WIDTH (pmq_pkg::ENTRY_W),
    .DEPTH (pmq_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != pmq_pkg::S_IDLE);
  assign out_valid = (state_r == pmq_pkg::S_RESP);
  assign out_data  = out_r;
  assign count_inc = count_r + 1'b1;
  assign count_dec = count_r - 1'b1;

  assign full = (pmq_pkg::CMP_W'(count_r) >= pmq_pkg::CMP_W'(max_msgs_r)) ||
                (pmq_pkg::CMP_W'(count_r) >= pmq_pkg::CMP_W'(pmq_pkg::CAPACITY));

  always_comb begin
    new_ent.prio    = pmq_pkg::PRIO_BITS'(in_data.priority_req);
    new_ent.length  = in_data.msg_length;
    new_ent.payload = in_data.payload_handle;
  end

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    j_nxt     = j_r;
    ent_nxt   = ent_r;
    out_nxt   = out_r;
    ram_we    = 1'b0;
    ram_waddr = head_r;
    ram_wdata = ent_r;
    ram_raddr = head_r;
    case (state_r)
      pmq_pkg::S_IDLE: begin
        out_nxt.out_length   = '0;
        out_nxt.out_priority = '0;
        out_nxt.out_payload  = '0;
        out_nxt.queued_count = 5'(count_r);
        ram_raddr = pmq_pkg::wrap_add(head_r, pmq_pkg::IDX_W'(count_dec));
        if (accept) begin
          state_nxt = pmq_pkg::S_RESP;
          ent_nxt   = new_ent;
          if (in_data.action == pmq_pkg::ACT_SEND) begin
            if (in_data.msg_length > max_size_r) begin
              out_nxt.status = pmq_pkg::ST_TOO_LONG;
            end else if (full) begin
              out_nxt.status = pmq_pkg::ST_FULL;
            end else if (count_r == '0) begin
              out_nxt.status       = pmq_pkg::ST_OK;
              out_nxt.queued_count = 5'(count_inc);
              ram_we    = 1'b1;
              ram_waddr = head_r;
              ram_wdata = new_ent;
              count_nxt = count_inc;
            end else begin
              out_nxt.status = pmq_pkg::ST_OK;
              j_nxt     = pmq_pkg::IDX_W'(count_dec);
              state_nxt = pmq_pkg::S_SCAN;
            end
          end else begin
            ram_raddr = head_r;
            if (in_data.msg_length < max_size_r) begin
              out_nxt.status = pmq_pkg::ST_SMALL_BUF;
            end else if (count_r == '0) begin
              out_nxt.status = pmq_pkg::ST_EMPTY;
            end else begin
              out_nxt.status = pmq_pkg::ST_OK;
              state_nxt      = pmq_pkg::S_RDHEAD;
            end
          end
        end
      end
      pmq_pkg::S_RDHEAD: begin
        out_nxt.out_length   = ram_rdata.length;
        out_nxt.out_priority = 15'(ram_rdata.prio);
        out_nxt.out_payload  = ram_rdata.payload;
        out_nxt.queued_count = 5'(count_dec);
        head_nxt  = pmq_pkg::wrap_add(head_r, pmq_pkg::IDX_W'(1));
        count_nxt = count_dec;
        state_nxt = pmq_pkg::S_RESP;
      end
      pmq_pkg::S_SCAN: begin
        ram_we    = 1'b1;
        ram_waddr = pmq_pkg::wrap_add(head_r, j_r + 1'b1);
        ram_raddr = pmq_pkg::wrap_add(head_r, j_r - 1'b1);
        if (ram_rdata.prio < ent_r.prio) begin
          ram_wdata = ram_rdata;
          if (j_r == '0) begin
            state_nxt = pmq_pkg::S_PLACE;
          end else begin
            j_nxt = j_r - 1'b1;
          end
        end else begin
          ram_wdata            = ent_r;
          count_nxt            = count_inc;
          out_nxt.queued_count = 5'(count_inc);
          state_nxt            = pmq_pkg::S_RESP;
        end
      end
      pmq_pkg::S_PLACE: begin
        ram_we               = 1'b1;
        ram_waddr            = head_r;
        ram_wdata            = ent_r;
        count_nxt            = count_inc;
        out_nxt.queued_count = 5'(count_inc);
        state_nxt            = pmq_pkg::S_RESP;
      end
      pmq_pkg::S_RESP: begin
        if (!out_stall) state_nxt = pmq_pkg::S_IDLE;
      end
      default: begin
        state_nxt = pmq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= pmq_pkg::S_IDLE;
      head_r     <= '0;
      count_r    <= '0;
      max_msgs_r <= pmq_pkg::MAX_MESSAGES_RST;
      max_size_r <= pmq_pkg::MAX_MESSAGE_SIZE_RST;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      if (cfg_we) begin
        case (cfg_index)
          pmq_pkg::REG_MAX_MESSAGES:     max_msgs_r <= pmq_pkg::MAXMSG_W'(cfg_wdata);
          pmq_pkg::REG_MAX_MESSAGE_SIZE: max_size_r <= pmq_pkg::SIZE_W'(cfg_wdata);
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    j_r   <= j_nxt;
    ent_r <= ent_nxt;
    out_r <= out_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pmq_pkg::CMP_W'(count_r) <= pmq_pkg::CMP_W'(pmq_pkg::CAPACITY))
    else $error("queue count above capacity");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pmq_pkg::S_SCAN) |-> (pmq_pkg::CNT_W'(j_r) < count_r))
    else $error("scan index outside held entries");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("request taken while busy");

  a_error_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != pmq_pkg::ST_OK) |->
      (out_data.out_length == '0 && out_data.out_priority == '0 &&
       out_data.out_payload == '0))
    else $error("refused request carries message fields");

  a_refused_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != pmq_pkg::ST_OK) |->
      (5'(count_r) == out_data.queued_count))
    else $error("count changed on refused request");

endmodule
